FILE: hw/rtl/smssd_pkg.sv
// package for the segment-multiplexed seven-segment driver
// holds payload structs, register indexes, scan constants and the glyph table
// no dependencies
package smssd_pkg;

    localparam int SEG_COUNT = 7;
    localparam int DIGIT_COUNT = 4;
    localparam int SEG_IDX_W = 3;
    localparam int DWELL_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEG_IDX_W-1:0] SEG_LAST = 3'd6;
    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd148;

    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_ANODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 1'b1;

    localparam logic [1:0] MODE_HEX = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_SDEC = 2'd2;
    localparam logic [1:0] MODE_BLANK = 2'd3;

    localparam logic [6:0] GLYPH_MINUS = 7'h40;
    localparam logic [6:0] GLYPH_BLANK = 7'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       latch;
        logic [1:0] mode;
    } t_in;

    typedef struct packed {
        logic [6:0] segment_drive;
        logic [3:0] digit_drive;
        logic [2:0] active_segment;
    } t_out;

    function automatic logic [6:0] hex_glyph(input logic [3:0] nib);
        logic [6:0] g;
        case (nib)
            4'h0: g = 7'h3f;
            4'h1: g = 7'h06;
            4'h2: g = 7'h5b;
            4'h3: g = 7'h4f;
            4'h4: g = 7'h66;
            4'h5: g = 7'h6d;
            4'h6: g = 7'h7d;
            4'h7: g = 7'h07;
            4'h8: g = 7'h7f;
            4'h9: g = 7'h6f;
            4'ha: g = 7'h77;
            4'hb: g = 7'h7c;
            4'hc: g = 7'h39;
            4'hd: g = 7'h5e;
            4'he: g = 7'h79;
            4'hf: g = 7'h71;
            default: g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

endpackage

FILE: hw/rtl/smssd_in_stage.sv
// input register with skid entry for the seven-segment driver
// stall is driven from the skid entry, so it is a register output
// depends on smssd_pkg
module smssd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  smssd_pkg::t_in   i_data,
    output logic             o_valid,
    output smssd_pkg::t_in   o_data,
    input  logic             i_take
);
    import smssd_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_in  r_main;
    t_in  r_skid;
    logic in_xfer;
    logic move;

    assign in_xfer = i_valid && !r_skid_valid;
    assign move    = r_main_valid && i_take;
    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (move) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (in_xfer) begin
            if (!r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without main entry");
`endif

endmodule

FILE: hw/rtl/smssd_core.sv
// scan state, mask rebuild and result register of the seven-segment driver
// holds configuration registers; depends on smssd_pkg
module smssd_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  smssd_pkg::t_in                      i_data,
    output logic                                o_take,
    output logic                                o_valid,
    input  logic                                i_stall,
    output smssd_pkg::t_out                     o_data,
    input  logic                                i_cfg_we,
    input  logic [smssd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [smssd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import smssd_pkg::*;

    logic                  r_common_anode;
    logic [DWELL_W-1:0]    r_dwell_ticks;
    logic [7:0]            r_held_data;
    logic [1:0]            r_held_mode;
    logic [DIGIT_COUNT-1:0] r_mask [SEG_COUNT];
    logic [SEG_IDX_W-1:0]  r_seg_idx;
    logic [DWELL_W-1:0]    r_dwell_cnt;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                  move;
    logic                  change;
    logic [7:0]            n_held_data;
    logic [SEG_IDX_W-1:0]  n_seg_idx;
    logic [DWELL_W-1:0]    n_dwell_cnt;
    logic [DWELL_W-1:0]    limit;
    logic                  neg;
    logic [7:0]            mag;
    logic [1:0]            hundreds;
    logic [6:0]            rem;
    logic [14:0]           tens_prod;
    logic [3:0]            tens;
    logic [3:0]            ones;
    logic [6:0]            pat [DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0] n_mask [SEG_COUNT];
    t_out                  result;

    assign move    = i_valid && (!r_out_valid || !i_stall);
    assign o_take  = !r_out_valid || !i_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // result from the state at the start of the transfer
    always_comb begin
        result.active_segment = r_seg_idx;
        result.segment_drive  = 7'(7'b1 << r_seg_idx);
        result.digit_drive    = r_mask[r_seg_idx];
        if (r_common_anode) begin
            result.segment_drive = ~result.segment_drive;
        end else begin
            result.digit_drive = ~result.digit_drive;
        end
    end

    // digit patterns for the new held value
    always_comb begin
        change = (i_data.latch && (i_data.data_byte != r_held_data))
            || (i_data.mode != r_held_mode);
        n_held_data = i_data.latch ? i_data.data_byte : r_held_data;
        neg = (i_data.mode == MODE_SDEC) && n_held_data[7];
        mag = neg ? 8'(8'd0 - n_held_data) : n_held_data;
        if (mag >= 8'd200) begin
            hundreds = 2'd2;
        end else if (mag >= 8'd100) begin
            hundreds = 2'd1;
        end else begin
            hundreds = 2'd0;
        end
        rem = 7'(mag - 8'(hundreds) * 8'd100);
        tens_prod = 15'(rem) * 15'd205;
        tens = 4'(tens_prod >> 11);
        ones = 4'(rem - 7'(tens) * 7'd10);
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            pat[d] = GLYPH_BLANK;
        end
        case (i_data.mode)
            MODE_HEX: begin
                pat[2] = hex_glyph(n_held_data[7:4]);
                pat[3] = hex_glyph(n_held_data[3:0]);
            end
            MODE_UDEC, MODE_SDEC: begin
                if (neg) begin
                    pat[0] = GLYPH_MINUS;
                end
                pat[1] = hex_glyph({2'b00, hundreds});
                pat[2] = hex_glyph(tens);
                pat[3] = hex_glyph(ones);
            end
            default: begin
                pat[0] = GLYPH_BLANK;
            end
        endcase
        for (int s = 0; s < SEG_COUNT; s++) begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                n_mask[s][d] = pat[d][s];
            end
        end
    end

    // scan advance
    always_comb begin
        limit = (r_dwell_ticks == '0) ? DWELL_W'(1) : r_dwell_ticks;
        n_seg_idx = (r_seg_idx >= SEG_LAST) ? '0 : 3'(r_seg_idx + 3'd1);
        n_dwell_cnt = DWELL_W'(r_dwell_cnt + DWELL_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_anode <= 1'b1;
            r_dwell_ticks  <= DWELL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COMMON_ANODE: r_common_anode <= i_cfg_data[0];
                CFG_DWELL_TICKS:  r_dwell_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_data <= '0;
            r_held_mode <= MODE_BLANK;
            for (int s = 0; s < SEG_COUNT; s++) begin
                r_mask[s] <= '0;
            end
            r_seg_idx   <= '0;
            r_dwell_cnt <= '0;
        end else if (move) begin
            if (change) begin
                r_held_data <= n_held_data;
                r_held_mode <= i_data.mode;
                for (int s = 0; s < SEG_COUNT; s++) begin
                    r_mask[s] <= n_mask[s];
                end
                r_seg_idx   <= n_seg_idx;
                r_dwell_cnt <= '0;
            end else if (n_dwell_cnt >= limit) begin
                r_seg_idx   <= n_seg_idx;
                r_dwell_cnt <= '0;
            end else begin
                r_dwell_cnt <= n_dwell_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= result;
        end
    end

`ifndef SYNTHESIS
    a_seg_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_idx <= SEG_LAST)
        else $error("segment index out of range");

    a_out_kept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid)
        else $error("result dropped while stalled");

    a_scan_moves_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && change |=> r_dwell_cnt == '0)
        else $error("dwell not restarted after display change");
`endif

endmodule

FILE: hw/rtl/segment_multiplexed_seven_seg_driver.sv
// top level of the segment-multiplexed four-digit seven-segment driver
// registers in the path: input register, then core state and result registers
// throughput: one transfer per cycle in both directions when the output is not stalled
// reset: synchronous active low; display blank, scan at segment A, common anode, dwell 148
// instantiates smssd_in_stage and smssd_core; depends on smssd_pkg
module segment_multiplexed_seven_seg_driver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  smssd_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output smssd_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_we,
    input  logic [smssd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [smssd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import smssd_pkg::*;

    logic buf_valid;
    t_in  buf_data;
    logic core_take;

    smssd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (buf_valid),
        .o_data  (buf_data),
        .i_take  (core_take)
    );

    smssd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (buf_valid),
        .i_data     (buf_data),
        .o_take     (core_take),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule
